@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property templates for the checkers, clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mi3_pkg.sv @@
// ---------------------------------------------------------------------------
// mi3_pkg
// Types, operand table and saturation helper for the 3x3 inverse.
// ---------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_W = 32;
  localparam int PROD_W = 65;
  localparam int WIDE_W = 136;

  typedef logic [WIDE_W-1:0]        wide_t;
  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [PROD_W-1:0]        prod_t;

  // operand addresses x, y, u, v of each cofactor x*y - u*v, row-major
  localparam logic [3:0] COF_IDX [36] = '{
    4'd4, 4'd8, 4'd5, 4'd7,
    4'd2, 4'd7, 4'd1, 4'd8,
    4'd1, 4'd5, 4'd2, 4'd4,
    4'd5, 4'd6, 4'd3, 4'd8,
    4'd0, 4'd8, 4'd2, 4'd6,
    4'd2, 4'd3, 4'd0, 4'd5,
    4'd3, 4'd7, 4'd4, 4'd6,
    4'd1, 4'd6, 4'd0, 4'd7,
    4'd0, 4'd4, 4'd1, 4'd3
  };

  // clamp a magnitude with sign into the signed 32-bit range
  function automatic elem_t sat32(wide_t mag, logic neg);
    elem_t r;
    if (neg) begin
      if (mag > wide_t'(33'h0_8000_0000)) r = elem_t'(32'h8000_0000);
      else r = elem_t'(32'd0 - mag[ELEM_W-1:0]);
    end else begin
      if (mag > wide_t'(32'h7FFF_FFFF)) r = elem_t'(32'h7FFF_FFFF);
      else r = elem_t'(mag[ELEM_W-1:0]);
    end
    return r;
  endfunction

endpackage

@@ hdl/matrix_inverse_3x3.sv @@
// ---------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 fixed-point inverse by adjugate and determinant, one shared multiplier
// and one shared restoring divider under a small sequencer.
// ---------------------------------------------------------------------------
// Channel  Dir  Signals                            Contents
// in       in   in_tvalid/in_tready/in_tdata       a_element, row-major
// out      out  out_tvalid/out_tready/out_tdata    inv_element, singular, last
//               out_tuser/out_tlast
// cfg      in   cfg_valid/cfg_ready/cfg_data       singular_threshold
//
// Nine input transfers load the matrix, one per cycle. The ninth starts a
// computation: 18 element products, 6 determinant partial products, the
// determinant checks, then per result either the singular output or a
// restoring division of 33 divider steps, plus output handshake.
// Reset (rst_n low, synchronous) returns to loading with an empty count.
// A stalled result holds in the output register; input stays blocked until
// the ninth result transfers. cfg_ready is always high.
// ---------------------------------------------------------------------------
module matrix_inverse_3x3
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] a_element
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] inv_element
  output logic        out_tuser,  // [0] singular
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data    // [30:0] singular_threshold
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CRDA  = 4'd1;
  localparam logic [3:0] S_CRDB  = 4'd2;
  localparam logic [3:0] S_DRD   = 4'd3;
  localparam logic [3:0] S_ABS   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_SING  = 4'd8;
  localparam logic [3:0] S_ORD   = 4'd9;
  localparam logic [3:0] S_PREP  = 4'd10;
  localparam logic [3:0] S_SETUP = 4'd11;
  localparam logic [3:0] S_DIV   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  localparam int ELEM_LAST = 8;
  localparam int COF_STEPS = 18;
  localparam int DET_STEPS = 6;
  localparam int DIV_BITS  = 32;

  // control
  logic [3:0]  state_r, state_nxt;
  logic [3:0]  load_cnt_r;
  logic [4:0]  step_r;
  logic        det_ph_r;
  logic [3:0]  idx_r;
  logic [5:0]  cnt_r;
  logic [30:0] thr_r;

  // storage
  elem_t       mat_mem [9];
  elem_t       rd_r;
  logic [3:0]  mem_raddr;
  logic signed [PROD_W-1:0] cof_mem [9];
  logic signed [PROD_W-1:0] cof_rd_r;
  logic [3:0]  cof_raddr;

  // datapath
  elem_t       op_a_r;
  logic [31:0] a_mag_r;
  logic [32:0] b_mag_r;
  logic        neg_r, sh_r;
  prod_t       prod_r;
  wide_t       acc_r, acc_nxt, term;
  wide_t       dmag_r;
  logic        dneg_r, sing_r;
  wide_t       cmag_r;
  logic        cneg_r;
  wide_t       rem_r, dsh_r;
  logic [32:0] q_r;
  logic        div_ge;
  elem_t       out_data_r;
  logic        out_valid_r;

  elem_t       a_src;
  logic [31:0] a_abs, b_abs;
  prod_t       cmag65;

  assign in_tready  = (state_r == S_LOAD);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = sing_r;
  assign out_tlast  = (idx_r == 4'(ELEM_LAST));

  // read addresses for the element store and the cofactor store
  always_comb begin
    mem_raddr = '0;
    cof_raddr = idx_r;
    case (state_r)
      S_CRDA: mem_raddr = COF_IDX[{step_r, 1'b0}];
      S_CRDB: mem_raddr = COF_IDX[{step_r, 1'b1}];
      S_DRD: begin
        mem_raddr = {2'b00, step_r[2:1]};
        cof_raddr = {step_r[2:1], 1'b0} + {2'b00, step_r[2:1]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_r     <= mat_mem[mem_raddr];
    cof_rd_r <= cof_mem[cof_raddr];
    if (in_tvalid && in_tready) mat_mem[load_cnt_r] <= elem_t'(in_tdata);
    if (state_r == S_ACC && !det_ph_r && step_r[0]) begin
      cof_mem[step_r[4:1]] <= acc_nxt[PROD_W-1:0];
    end
  end

  // operand magnitudes
  always_comb begin
    a_src  = det_ph_r ? rd_r : op_a_r;
    a_abs  = a_src[31] ? 32'd0 - a_src : a_src;
    b_abs  = rd_r[31] ? 32'd0 - rd_r : rd_r;
    cmag65 = cof_rd_r[PROD_W-1] ? prod_t'(-cof_rd_r) : prod_t'(cof_rd_r);
  end

  // shared accumulator adder
  always_comb begin
    term    = sh_r ? (wide_t'(prod_r) << 32) : wide_t'(prod_r);
    acc_nxt = neg_r ? acc_r - term : acc_r + term;
  end

  assign div_ge = (rem_r >= dsh_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:  if (in_tvalid && load_cnt_r == 4'(ELEM_LAST)) state_nxt = S_CRDA;
      S_CRDA:  state_nxt = S_CRDB;
      S_CRDB:  state_nxt = S_ABS;
      S_DRD:   state_nxt = S_ABS;
      S_ABS:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ACC;
      S_ACC: begin
        if (!det_ph_r) state_nxt = (step_r == 5'(COF_STEPS - 1)) ? S_DRD : S_CRDA;
        else state_nxt = (step_r == 5'(DET_STEPS - 1)) ? S_CHK : S_DRD;
      end
      S_CHK:   state_nxt = S_SING;
      S_SING:  state_nxt = S_ORD;
      S_ORD:   state_nxt = S_PREP;
      S_PREP:  state_nxt = S_SETUP;
      S_SETUP: state_nxt = sing_r ? S_OUT : S_DIV;
      S_DIV:   if (cnt_r == '0) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) state_nxt = (idx_r == 4'(ELEM_LAST)) ? S_LOAD : S_ORD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      step_r      <= '0;
      det_ph_r    <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) thr_r <= cfg_data;
      unique case (state_r)
        S_LOAD: begin
          if (in_tvalid) begin
            // ninth element: restart the count, clear accumulator
            if (load_cnt_r == 4'(ELEM_LAST)) begin
              load_cnt_r <= '0;
              step_r     <= '0;
              det_ph_r   <= 1'b0;
              acc_r      <= '0;
            end else begin
              load_cnt_r <= load_cnt_r + 4'd1;
            end
          end
        end
        S_CRDB: op_a_r <= rd_r;
        S_ABS: begin
          a_mag_r <= a_abs;
          if (!det_ph_r) begin
            b_mag_r <= {1'b0, b_abs};
            neg_r   <= a_src[31] ^ rd_r[31] ^ step_r[0];
            sh_r    <= 1'b0;
          end else begin
            b_mag_r <= step_r[0] ? cmag65[64:32] : {1'b0, cmag65[31:0]};
            neg_r   <= a_src[31] ^ cof_rd_r[PROD_W-1];
            sh_r    <= step_r[0];
          end
        end
        S_MUL: prod_r <= {33'd0, a_mag_r} * {32'd0, b_mag_r};
        S_ACC: begin
          if (!det_ph_r) begin
            // drop the finished cofactor from the accumulator
            acc_r <= step_r[0] ? '0 : acc_nxt;
            if (step_r == 5'(COF_STEPS - 1)) begin
              step_r   <= '0;
              det_ph_r <= 1'b1;
            end else begin
              step_r <= step_r + 5'd1;
            end
          end else begin
            acc_r  <= acc_nxt;
            step_r <= step_r + 5'd1;
          end
        end
        S_CHK: begin
          dneg_r <= acc_r[WIDE_W-1];
          dmag_r <= acc_r[WIDE_W-1] ? wide_t'(-acc_r) : acc_r;
        end
        S_SING: begin
          sing_r <= (dmag_r == '0) || (dmag_r < (wide_t'(thr_r) << (2 * FRAC_BITS)));
          idx_r  <= '0;
        end
        S_ORD: ;
        S_PREP: begin
          cmag_r <= wide_t'(cmag65);
          cneg_r <= cof_rd_r[PROD_W-1];
        end
        S_SETUP: begin
          if (sing_r) begin
            out_data_r  <= sat32(cmag_r >> FRAC_BITS, cneg_r);
            out_valid_r <= 1'b1;
          end else begin
            rem_r <= cmag_r << (2 * FRAC_BITS);
            dsh_r <= dmag_r << DIV_BITS;
            q_r   <= '0;
            cnt_r <= 6'(DIV_BITS);
          end
        end
        S_DIV: begin
          // one restoring quotient bit; bit 32 set means saturate
          if (div_ge) rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[31:0], div_ge};
          dsh_r <= dsh_r >> 1;
          if (cnt_r != '0) cnt_r <= cnt_r - 6'd1;
        end
        S_FIN: begin
          out_data_r  <= sat32(wide_t'(q_r), cneg_r ^ dneg_r);
          out_valid_r <= 1'b1;
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (idx_r != 4'(ELEM_LAST)) idx_r <= idx_r + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/mi3_checker.sv @@
// ---------------------------------------------------------------------------
// mi3_checker
// Port-level checks on the 3x3 inverse, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mi3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  `CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `CHK_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "stalled result changed")
  `CHK_NOW(a_no_overlap, out_tvalid, !in_tready, "input open while result pending")
  `CHK_NEXT(a_reopen, out_tvalid && out_tready && out_tlast, in_tready, "input not reopened")

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (.*);

@@ test/tb_matrix_inverse_3x3.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_matrix_inverse_3x3
// Streams 3x3 Q16.16 matrices into the inverter and checks the nine results
// of each against a local adjugate/determinant predictor with exact 128-bit
// arithmetic, over several thresholds and idle patterns on both channels.
// ---------------------------------------------------------------------------
module tb_matrix_inverse_3x3;
  import mi3_pkg::*;

  localparam int  FRAC     = 16;
  localparam int  MAX_CYC  = 2000000;
  localparam int  HOLD_OFF = 20;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  typedef logic signed [127:0] s128_t;
  typedef logic [127:0]        u128_t;

  typedef struct packed {
    logic [31:0] inv_element;
    logic        singular;
    logic        last;
  } inv_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] a_element
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] inv_element
  logic        out_tuser;       // [0] singular
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_data = '0;   // [30:0] singular_threshold

  matrix_inverse_3x3 #(.FRAC_BITS(FRAC)) dut (.*);

  // pending elements, expected inverse elements, predictor state
  logic [31:0] elem_q[$];
  inv_res_t    inv_q[$];
  logic [31:0] mat_buf[9];
  int          load_cnt = 0;
  logic [30:0] thr_reg = '0;
  int          send_idle = 0, recv_idle = 0;
  int          errors = 0, cycles = 0;
  logic        took = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic logic [31:0] clamp32(u128_t mag, logic neg);
    if (neg) return (mag > 128'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
    return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic s128_t elem_w(int i);
    return s128_t'($signed(mat_buf[i]));
  endfunction

  function automatic s128_t cofactor(int x, int y, int u, int v);
    return elem_w(x) * elem_w(y) - elem_w(u) * elem_w(v);
  endfunction

  // load one element; the ninth produces the nine expected results
  function automatic void load_element(logic [31:0] e);
    s128_t c[9];
    s128_t det;
    u128_t dmag, mag, thr;
    logic  sing, neg;
    inv_res_t r;
    mat_buf[load_cnt] = e;
    load_cnt++;
    if (load_cnt < 9) return;
    load_cnt = 0;
    c[0] = cofactor(4, 8, 5, 7);
    c[1] = cofactor(2, 7, 1, 8);
    c[2] = cofactor(1, 5, 2, 4);
    c[3] = cofactor(5, 6, 3, 8);
    c[4] = cofactor(0, 8, 2, 6);
    c[5] = cofactor(2, 3, 0, 5);
    c[6] = cofactor(3, 7, 4, 6);
    c[7] = cofactor(1, 6, 0, 7);
    c[8] = cofactor(0, 4, 1, 3);
    det  = elem_w(0) * c[0] + elem_w(1) * c[3] + elem_w(2) * c[6];
    dmag = det[127] ? u128_t'(-det) : u128_t'(det);
    thr  = u128_t'(thr_reg) << (2 * FRAC);
    sing = (det == 0) || (dmag < thr);
    for (int i = 0; i < 9; i++) begin
      neg = c[i][127];
      mag = neg ? u128_t'(-c[i]) : u128_t'(c[i]);
      if (sing) r.inv_element = clamp32(mag >> FRAC, neg);
      else r.inv_element = clamp32((mag << (2 * FRAC)) / dmag, neg ^ det[127]);
      r.singular = sing;
      r.last     = (i == 8);
      inv_q.push_back(r);
    end
  endfunction

  // mixed element values: full range, small reals, zero, extremes, tiny
  function automatic logic [31:0] rand_element();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5: return ($urandom_range(0, 8) - 4) * Q_ONE + $urandom_range(0, 16'hFFFF);
      6:       return '0;
      7:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 255) - 128;
    endcase
  endfunction

  task automatic push_matrix();
    logic [31:0] m[9];
    for (int i = 0; i < 9; i++) m[i] = rand_element();
    // force a zero determinant now and then: repeat a row or zero a column
    case ($urandom_range(0, 5))
      0: for (int i = 0; i < 3; i++) m[6 + i] = m[i];
      1: for (int i = 0; i < 3; i++) m[3 * i + 1] = '0;
      default: ;
    endcase
    foreach (m[i]) elem_q.push_back(m[i]);
  endtask

  // block until every element went in and every result came out
  task automatic drain();
    while (elem_q.size() != 0 || in_tvalid || inv_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [30:0] t);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= t;
    do @(posedge clk); while (!cfg_ready);
    thr_reg = t;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int nmat, int s_idle, int r_idle, logic [30:0] t);
    drain();
    repeat (HOLD_OFF) @(posedge clk);
    write_threshold(t);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int k = 0; k < nmat; k++) push_matrix();
  endtask

  // driver: advance to the next element after a transfer, idle at random
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || took)) begin
      if (elem_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        in_tvalid <= 1'b1;
        in_tdata  <= elem_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    if (rst_n) out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // monitor: feed the predictor on input transfers, check output transfers
  always @(posedge clk) begin
    inv_res_t want;
    cycles++;
    took = in_tvalid && in_tready && rst_n;
    if (took) load_element(in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      if (inv_q.size() == 0) begin
        if (errors < 10) $display("unexpected result %h", out_tdata);
        errors++;
      end else begin
        want = inv_q.pop_front();
        if (want != {out_tdata, out_tuser, out_tlast}) begin
          if (errors < 10)
            $display("mismatch: exp inv=%h sing=%b last=%b, got inv=%h sing=%b last=%b",
                     want.inv_element, want.singular, want.last,
                     out_tdata, out_tuser, out_tlast);
          errors++;
        end
      end
    end
    if (cycles > MAX_CYC) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, at the reset threshold: identity, tiny diagonal (saturates),
    // and a matrix of the extreme values
    send_idle = 12;
    recv_idle = 59;
    foreach (mat_buf[i]) elem_q.push_back((i % 4 == 0) ? Q_ONE : 32'd0);
    foreach (mat_buf[i])
      elem_q.push_back(i == 0 ? 32'd1 : i == 4 ? 32'd2 : i == 8 ? -32'sd3 : 32'd0);
    foreach (mat_buf[i])
      elem_q.push_back(i % 4 == 0 ? 32'h7FFF_FFFF : i % 4 == 1 ? 32'h8000_0000 : 32'd0);

    run_phase(11, 12, 59, 31'(Q_ONE));
    run_phase(11, 59, 12, 31'h7FFF_FFFF);
    run_phase(6, 0, 0, 31'($urandom_range(0, 32'h00FF_FFFF)));
    run_phase(5, 0, 0, 31'd0);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ matrix_inverse_3x3.f @@
+incdir+hdl
hdl/mi3_pkg.sv
hdl/matrix_inverse_3x3.sv
hdl/mi3_checker.sv
test/tb_matrix_inverse_3x3.sv
